FILE: hw/rtl/xcfr_pkg.sv
`default_nettype none

package xcfr_pkg;

    localparam int LEN_W = 7;

    typedef logic [LEN_W-1:0] t_len;

    typedef enum logic [2:0] {
        PH_HUNT,
        PH_ID,
        PH_LEN,
        PH_DATA,
        PH_CSUM,
        PH_END
    } t_phase;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_LOAD,
        BK_SHOW
    } t_back_state;

    localparam logic REG_START_MARKER = 1'b0;
    localparam logic REG_END_MARKER   = 1'b1;

    localparam logic [7:0] START_MARKER_RESET = 8'd170;
    localparam logic [7:0] END_MARKER_RESET   = 8'd85;

    localparam logic STATUS_OK       = 1'b0;
    localparam logic STATUS_CSUM_ERR = 1'b1;

    typedef struct packed {
        logic       status;
        logic [7:0] id;
        t_len       len;
        logic       bank;
    } t_frame_desc;

endpackage

`default_nettype wire

FILE: hw/rtl/xcfr_ram.sv
`default_nettype none

module xcfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hw/rtl/xcfr_front.sv
`default_nettype none

module xcfr_front #(
    parameter int MAX_PAYLOAD = 32,
    parameter int PW          = 5
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic                 i_cfg_idx,
    input  wire logic [7:0]           i_cfg_wdata,
    input  wire logic                 i_rx_valid,
    output logic                      o_rx_ready,
    input  wire logic [7:0]           i_rx_octet,
    input  wire logic                 i_q_room,
    output logic                      o_push,
    output xcfr_pkg::t_frame_desc     o_desc,
    output logic                      o_wr_en,
    output logic [PW:0]               o_wr_addr,
    output logic [7:0]                o_wr_data
);

    xcfr_pkg::t_phase r_phase;
    xcfr_pkg::t_phase n_phase;
    logic [7:0]       r_start_marker;
    logic [7:0]       r_end_marker;
    logic [7:0]       r_id;
    logic [7:0]       n_id;
    xcfr_pkg::t_len   r_len;
    xcfr_pkg::t_len   n_len;
    xcfr_pkg::t_len   r_count;
    xcfr_pkg::t_len   n_count;
    logic [7:0]       r_xor;
    logic [7:0]       n_xor;
    logic [7:0]       r_csum;
    logic [7:0]       n_csum;
    logic             r_bank;
    logic             n_bank;
    logic             w_accept;
    xcfr_pkg::t_len   w_count_inc;

    assign o_rx_ready  = i_q_room;
    assign w_accept    = i_rx_valid & i_q_room;
    assign w_count_inc = r_count + xcfr_pkg::t_len'(1);

    always_comb begin
        n_phase = r_phase;
        if (w_accept) begin
            case (r_phase)
                xcfr_pkg::PH_HUNT: begin
                    if (i_rx_octet == r_start_marker) begin
                        n_phase = xcfr_pkg::PH_ID;
                    end
                end
                xcfr_pkg::PH_ID: begin
                    n_phase = xcfr_pkg::PH_LEN;
                end
                xcfr_pkg::PH_LEN: begin
                    if (i_rx_octet > 8'(MAX_PAYLOAD)) begin
                        n_phase = xcfr_pkg::PH_HUNT;
                    end else if (i_rx_octet == 8'd0) begin
                        n_phase = xcfr_pkg::PH_CSUM;
                    end else begin
                        n_phase = xcfr_pkg::PH_DATA;
                    end
                end
                xcfr_pkg::PH_DATA: begin
                    if (w_count_inc >= r_len) begin
                        n_phase = xcfr_pkg::PH_CSUM;
                    end
                end
                xcfr_pkg::PH_CSUM: begin
                    n_phase = xcfr_pkg::PH_END;
                end
                xcfr_pkg::PH_END: begin
                    n_phase = xcfr_pkg::PH_HUNT;
                end
                default: begin
                    n_phase = xcfr_pkg::PH_HUNT;
                end
            endcase
        end
    end

    always_comb begin
        n_id      = r_id;
        n_len     = r_len;
        n_count   = r_count;
        n_xor     = r_xor;
        n_csum    = r_csum;
        n_bank    = r_bank;
        o_push    = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = {r_bank, r_count[PW-1:0]};
        o_wr_data = i_rx_octet;
        o_desc    = '{status: (r_csum != r_xor) ? xcfr_pkg::STATUS_CSUM_ERR
                                                : xcfr_pkg::STATUS_OK,
                      id: r_id, len: r_len, bank: r_bank};
        if (w_accept) begin
            case (r_phase)
                xcfr_pkg::PH_ID: begin
                    n_id  = i_rx_octet;
                    n_xor = i_rx_octet;
                end
                xcfr_pkg::PH_LEN: begin
                    n_len   = xcfr_pkg::t_len'(i_rx_octet);
                    n_count = '0;
                    n_xor   = r_xor ^ i_rx_octet;
                end
                xcfr_pkg::PH_DATA: begin
                    o_wr_en = 1'b1;
                    n_xor   = r_xor ^ i_rx_octet;
                    n_count = w_count_inc;
                end
                xcfr_pkg::PH_CSUM: begin
                    n_csum = i_rx_octet;
                end
                xcfr_pkg::PH_END: begin
                    if (i_rx_octet == r_end_marker) begin
                        o_push = 1'b1;
                        n_bank = ~r_bank;
                    end
                end
                default: begin
                    n_count = r_count;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= xcfr_pkg::PH_HUNT;
            r_start_marker <= xcfr_pkg::START_MARKER_RESET;
            r_end_marker   <= xcfr_pkg::END_MARKER_RESET;
            r_bank         <= 1'b0;
        end else begin
            r_phase <= n_phase;
            r_bank  <= n_bank;
            if (i_cfg_we && i_cfg_idx == xcfr_pkg::REG_START_MARKER) begin
                r_start_marker <= i_cfg_wdata;
            end
            if (i_cfg_we && i_cfg_idx == xcfr_pkg::REG_END_MARKER) begin
                r_end_marker <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_id    <= n_id;
        r_len   <= n_len;
        r_count <= n_count;
        r_xor   <= n_xor;
        r_csum  <= n_csum;
    end

endmodule

`default_nettype wire

FILE: hw/rtl/xcfr_queue.sv
`default_nettype none

module xcfr_queue (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_push,
    input  wire xcfr_pkg::t_frame_desc i_desc,
    input  wire logic                  i_pop,
    output logic                       o_room,
    output logic                       o_head_valid,
    output xcfr_pkg::t_frame_desc      o_head
);

    xcfr_pkg::t_frame_desc r_entry [2];
    logic                  r_wr_ptr;
    logic                  r_rd_ptr;
    logic [1:0]            r_count;
    logic [1:0]            n_count;

    assign o_room       = (r_count != 2'd2);
    assign o_head_valid = (r_count != 2'd0);
    assign o_head       = r_entry[r_rd_ptr];

    always_comb begin
        n_count = r_count;
        if (i_push && !i_pop) begin
            n_count = r_count + 2'd1;
        end else if (i_pop && !i_push) begin
            n_count = r_count - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (i_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_desc;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/xcfr_back.sv
`default_nettype none

module xcfr_back #(
    parameter int PW = 5
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_head_valid,
    input  wire xcfr_pkg::t_frame_desc i_head,
    output logic                       o_pop,
    output logic [PW:0]                o_rd_addr,
    input  wire logic [7:0]            i_rd_data,
    output logic                       o_res_valid,
    input  wire logic                  i_res_ready,
    output logic                       o_frame_status,
    output logic [7:0]                 o_message_id,
    output logic [5:0]                 o_payload_length,
    output logic [4:0]                 o_payload_position,
    output logic [7:0]                 o_payload_octet,
    output logic                       o_run_last
);

    xcfr_pkg::t_back_state r_state;
    xcfr_pkg::t_back_state n_state;
    xcfr_pkg::t_len        r_pos;
    xcfr_pkg::t_len        n_pos;
    logic                  r_status;
    logic [7:0]            r_id;
    logic [5:0]            r_len;
    logic [4:0]            r_pos_out;
    logic [7:0]            r_octet;
    logic                  r_last;
    logic                  n_load;
    logic                  w_single;
    logic                  w_last;

    assign w_single  = (i_head.status == xcfr_pkg::STATUS_CSUM_ERR) ||
                       (i_head.len == '0);
    assign w_last    = w_single || ((r_pos + xcfr_pkg::t_len'(1)) == i_head.len);
    assign o_rd_addr = {i_head.bank, r_pos[PW-1:0]};

    always_comb begin
        n_state = r_state;
        case (r_state)
            xcfr_pkg::BK_IDLE: begin
                if (i_head_valid) begin
                    n_state = xcfr_pkg::BK_READ;
                end
            end
            xcfr_pkg::BK_READ: begin
                n_state = xcfr_pkg::BK_LOAD;
            end
            xcfr_pkg::BK_LOAD: begin
                n_state = xcfr_pkg::BK_SHOW;
            end
            xcfr_pkg::BK_SHOW: begin
                if (i_res_ready) begin
                    n_state = r_last ? xcfr_pkg::BK_IDLE : xcfr_pkg::BK_READ;
                end
            end
            default: begin
                n_state = xcfr_pkg::BK_IDLE;
            end
        endcase
    end

    always_comb begin
        n_pos  = r_pos;
        n_load = 1'b0;
        o_pop  = 1'b0;
        case (r_state)
            xcfr_pkg::BK_IDLE: begin
                n_pos = '0;
            end
            xcfr_pkg::BK_LOAD: begin
                n_load = 1'b1;
            end
            xcfr_pkg::BK_SHOW: begin
                if (i_res_ready) begin
                    if (r_last) begin
                        o_pop = 1'b1;
                    end else begin
                        n_pos = r_pos + xcfr_pkg::t_len'(1);
                    end
                end
            end
            default: begin
                n_pos = r_pos;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= xcfr_pkg::BK_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pos <= n_pos;
        if (n_load) begin
            r_status  <= i_head.status;
            r_id      <= i_head.id;
            r_len     <= i_head.len[5:0];
            r_pos_out <= w_single ? 5'd0 : r_pos[4:0];
            r_octet   <= w_single ? 8'd0 : i_rd_data;
            r_last    <= w_last;
        end
    end

    assign o_res_valid        = (r_state == xcfr_pkg::BK_SHOW);
    assign o_frame_status     = r_status;
    assign o_message_id       = r_id;
    assign o_payload_length   = r_len;
    assign o_payload_position = r_pos_out;
    assign o_payload_octet    = r_octet;
    assign o_run_last         = r_last;

endmodule

`default_nettype wire

FILE: hw/rtl/xor_checksum_frame_receiver_top.sv
`default_nettype none

// Receives a byte stream framed as start marker, message id, length, payload, XOR checksum and
// end marker, and delivers each frame with a good end marker as results: one per payload byte
// with status ok, or a single result for an empty payload or a checksum mismatch. The parser
// takes one byte per cycle while it is not stalled. Payload bytes go into a two-bank buffer
// memory, and each completed frame waits in a two-entry queue for the readout stage. For each
// result the readout stage steps through a memory address state, a registered read and an
// output register; it passes through an idle state before the first result of each frame and
// waits while the consumer holds ready low. Byte transfers stall only while the queue holds two
// finished frames whose readout is not yet complete. There is no clearing pass after reset.
module xor_checksum_frame_receiver_top #(
    parameter int MAX_PAYLOAD = 32
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_idx,
    input  wire logic [7:0] i_cfg_wdata,
    input  wire logic       i_rx_valid,
    output logic            o_rx_ready,
    input  wire logic [7:0] i_rx_octet,
    output logic            o_res_valid,
    input  wire logic       i_res_ready,
    output logic            o_frame_status,
    output logic [7:0]      o_message_id,
    output logic [5:0]      o_payload_length,
    output logic [4:0]      o_payload_position,
    output logic [7:0]      o_payload_octet,
    output logic            o_run_last
);

    localparam int PW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
    localparam int DEPTH = 2 ** (PW + 1);

    logic                  w_q_room;
    logic                  w_push;
    xcfr_pkg::t_frame_desc w_desc;
    logic                  w_pop;
    logic                  w_head_valid;
    xcfr_pkg::t_frame_desc w_head;
    logic                  w_wr_en;
    logic [PW:0]           w_wr_addr;
    logic [7:0]            w_wr_data;
    logic [PW:0]           w_rd_addr;
    logic [7:0]            w_rd_data;

    xcfr_front #(
        .MAX_PAYLOAD (MAX_PAYLOAD),
        .PW          (PW)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_rx_valid  (i_rx_valid),
        .o_rx_ready  (o_rx_ready),
        .i_rx_octet  (i_rx_octet),
        .i_q_room    (w_q_room),
        .o_push      (w_push),
        .o_desc      (w_desc),
        .o_wr_en     (w_wr_en),
        .o_wr_addr   (w_wr_addr),
        .o_wr_data   (w_wr_data)
    );

    xcfr_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_wr_en),
        .i_waddr (w_wr_addr),
        .i_wdata (w_wr_data),
        .i_raddr (w_rd_addr),
        .o_rdata (w_rd_data)
    );

    xcfr_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (w_push),
        .i_desc       (w_desc),
        .i_pop        (w_pop),
        .o_room       (w_q_room),
        .o_head_valid (w_head_valid),
        .o_head       (w_head)
    );

    xcfr_back #(
        .PW (PW)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_head_valid       (w_head_valid),
        .i_head             (w_head),
        .o_pop              (w_pop),
        .o_rd_addr          (w_rd_addr),
        .i_rd_data          (w_rd_data),
        .o_res_valid        (o_res_valid),
        .i_res_ready        (i_res_ready),
        .o_frame_status     (o_frame_status),
        .o_message_id       (o_message_id),
        .o_payload_length   (o_payload_length),
        .o_payload_position (o_payload_position),
        .o_payload_octet    (o_payload_octet),
        .o_run_last         (o_run_last)
    );

endmodule

`default_nettype wire
